/* rtl/iag_pkg.sv */
// iag_pkg: shared types and constants of the im2col address generator.
// Register codes, channel payload structs, the configuration bundle.
// No dependencies.
`default_nettype none

package iag_pkg;

  localparam int CFG_DIM_W   = 11;  // plane and channel registers
  localparam int CFG_TAP_W   = 4;   // kernel, stride, padding, dilation registers
  localparam int CFG_DATA_W  = 11;  // widest register
  localparam int CFG_INDEX_W = 3;
  localparam int IMG_ADDR_W  = 32;  // image_base and src_address

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_NUM_CHANNELS = 3'd0,
    REG_IN_HEIGHT    = 3'd1,
    REG_IN_WIDTH     = 3'd2,
    REG_KERNEL_ROWS  = 3'd3,
    REG_KERNEL_COLS  = 3'd4,
    REG_STEP_SIZE    = 3'd5,
    REG_PAD_SIZE     = 3'd6,
    REG_TAP_SPACING  = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic                  restart;
    logic [IMG_ADDR_W-1:0] image_base;
  } iag_item_t;

  typedef struct packed {
    logic [IMG_ADDR_W-1:0] src_address;
    logic                  is_pad;
    logic                  last;
    logic                  bad_config;
  } iag_result_t;

  // Effective configuration: zero counts forced to 1, dimensions saturated.
  typedef struct packed {
    logic [CFG_DIM_W-1:0] chans;
    logic [CFG_DIM_W-1:0] height;
    logic [CFG_DIM_W-1:0] width;
    logic [CFG_TAP_W-1:0] krows;
    logic [CFG_TAP_W-1:0] kcols;
    logic [CFG_TAP_W-1:0] step;
    logic [CFG_TAP_W-1:0] pad;
    logic [CFG_TAP_W-1:0] spacing;
  } iag_cfg_t;

  typedef struct packed {
    logic bad;
    logic last;
  } iag_flags_t;

endpackage

`default_nettype wire

/* rtl/iag_stream_if.sv */
// iag_item_if, iag_result_if: valid/ready channels of the address generator.
// Depends on iag_pkg for the payload structs.
`default_nettype none

interface iag_item_if;
  logic                valid;
  logic                ready;
  iag_pkg::iag_item_t  payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface iag_result_if;
  logic                 valid;
  logic                 ready;
  iag_pkg::iag_result_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

/* rtl/iag_cfg_regs.sv */
// iag_cfg_regs: configuration register file and effective-value cleanup.
// Depends on iag_pkg.
`default_nettype none

module iag_cfg_regs #(
  parameter int MAX_DIM = 1024,
  localparam int DIM_MAX = (MAX_DIM > 2047) ? 2047 : MAX_DIM
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_write,
  input  wire logic [iag_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  wire logic [iag_pkg::CFG_DATA_W-1:0]    cfg_data,
  output iag_pkg::iag_cfg_t                      cfg
);
  import iag_pkg::*;

  logic [CFG_DIM_W-1:0] num_channels, in_height, in_width;
  logic [CFG_TAP_W-1:0] kernel_rows, kernel_cols, step_size, pad_size, tap_spacing;
  logic [CFG_DIM_W-1:0] chans_sat;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_channels <= 11'd1;
      in_height    <= 11'd1;
      in_width     <= 11'd1;
      kernel_rows  <= 4'd1;
      kernel_cols  <= 4'd1;
      step_size    <= 4'd1;
      pad_size     <= 4'd0;
      tap_spacing  <= 4'd1;
    end else if (cfg_write) begin
      case (cfg_reg_t'(cfg_index))
        REG_NUM_CHANNELS: num_channels <= cfg_data;
        REG_IN_HEIGHT:    in_height    <= cfg_data;
        REG_IN_WIDTH:     in_width     <= cfg_data;
        REG_KERNEL_ROWS:  kernel_rows  <= cfg_data[CFG_TAP_W-1:0];
        REG_KERNEL_COLS:  kernel_cols  <= cfg_data[CFG_TAP_W-1:0];
        REG_STEP_SIZE:    step_size    <= cfg_data[CFG_TAP_W-1:0];
        REG_PAD_SIZE:     pad_size     <= cfg_data[CFG_TAP_W-1:0];
        REG_TAP_SPACING:  tap_spacing  <= cfg_data[CFG_TAP_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    chans_sat   = (num_channels > 11'(DIM_MAX)) ? 11'(DIM_MAX) : num_channels;
    cfg.chans   = (chans_sat == '0) ? 11'd1 : chans_sat;
    cfg.height  = (in_height > 11'(DIM_MAX)) ? 11'(DIM_MAX) : in_height;
    cfg.width   = (in_width > 11'(DIM_MAX)) ? 11'(DIM_MAX) : in_width;
    cfg.krows   = (kernel_rows == '0) ? 4'd1 : kernel_rows;
    cfg.kcols   = (kernel_cols == '0) ? 4'd1 : kernel_cols;
    cfg.step    = (step_size == '0) ? 4'd1 : step_size;
    cfg.pad     = pad_size;
    cfg.spacing = tap_spacing;
  end

endmodule

`default_nettype wire

/* rtl/iag_walker.sv */
// iag_walker: walk counters and first pipeline register of the address generator.
// Bounds come from multiply/compare against the extent numerator, no divider.
// Depends on iag_pkg.
`default_nettype none

module iag_walker #(
  parameter int MAX_DIM = 1024,
  localparam int DIM_MAX = (MAX_DIM > 2047) ? 2047 : MAX_DIM,
  localparam int DIM_W   = $clog2(DIM_MAX + 1),
  localparam int IDX_W   = $clog2(DIM_MAX),
  localparam int OIDX_W  = $clog2(DIM_MAX + 30),
  localparam int NW      = DIM_W + 5,
  localparam int CW      = OIDX_W + 5,
  localparam int RB_W    = NW - 1
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          advance,
  input  wire logic                          accept,
  input  wire logic                          restart,
  input  wire logic [iag_pkg::IMG_ADDR_W-1:0] image_base,
  input  wire iag_pkg::iag_cfg_t             cfg,
  output logic                               s1_valid,
  output iag_pkg::iag_flags_t                s1_flags,
  output logic [IDX_W-1:0]                   s1_chan,
  output logic [3:0]                         s1_krow,
  output logic [3:0]                         s1_kcol,
  output logic [RB_W-1:0]                    s1_row_base,
  output logic [RB_W-1:0]                    s1_col_base,
  output logic [iag_pkg::IMG_ADDR_W-1:0]     s1_base
);
  import iag_pkg::*;

  logic [IDX_W-1:0]  chan_idx, chan_next, c0, ce;
  logic [3:0]        krow_idx, krow_next, k0r, kre;
  logic [3:0]        kcol_idx, kcol_next, k0c, kce;
  logic [OIDX_W-1:0] orow_idx, orow_next, r0, ore;
  logic [OIDX_W-1:0] ocol_idx, ocol_next, q0, oce;
  logic [DIM_W-1:0]  ch, h, w;
  logic [7:0]        span_r, span_c;
  logic [NW-1:0]     num_r, num_c;
  logic [CW-1:0]     lim_r, lim_c, prod_r, prod_c, ore_s, oce_s;
  logic              bad, last_w;
  logic              ch_more, kr_more, kc_more, row_more, col_more;

  assign ch = cfg.chans[DIM_W-1:0];
  assign h  = cfg.height[DIM_W-1:0];
  assign w  = cfg.width[DIM_W-1:0];

  // Extent numerator n + 2p - d(k-1) - 1; its sign bit flags a bad window.
  always_comb begin
    span_r = cfg.spacing * (cfg.krows - 4'd1);
    span_c = cfg.spacing * (cfg.kcols - 4'd1);
    num_r  = NW'(h) + NW'({cfg.pad, 1'b0}) - NW'(span_r) - NW'(1);
    num_c  = NW'(w) + NW'({cfg.pad, 1'b0}) - NW'(span_c) - NW'(1);
    bad    = num_r[NW-1] | num_c[NW-1];
    lim_r  = CW'(num_r[NW-2:0]);
    lim_c  = CW'(num_c[NW-2:0]);
  end

  // Restart, then clear any counter left beyond a changed bound.
  // Output row o is in range while o*step <= numerator.
  always_comb begin
    c0  = restart ? '0 : chan_idx;
    k0r = restart ? '0 : krow_idx;
    k0c = restart ? '0 : kcol_idx;
    r0  = restart ? '0 : orow_idx;
    q0  = restart ? '0 : ocol_idx;

    ce  = (DIM_W'(c0) >= ch) ? '0 : c0;
    kre = (k0r >= cfg.krows) ? 4'd0 : k0r;
    kce = (k0c >= cfg.kcols) ? 4'd0 : k0c;

    prod_r = CW'(r0) * CW'(cfg.step);
    prod_c = CW'(q0) * CW'(cfg.step);
    ore    = (prod_r > lim_r) ? '0 : r0;
    ore_s  = (prod_r > lim_r) ? '0 : prod_r;
    oce    = (prod_c > lim_c) ? '0 : q0;
    oce_s  = (prod_c > lim_c) ? '0 : prod_c;

    ch_more  = ((DIM_W+1)'(ce) + (DIM_W+1)'(1)) < (DIM_W+1)'(ch);
    kr_more  = (5'(kre) + 5'd1) < 5'(cfg.krows);
    kc_more  = (5'(kce) + 5'd1) < 5'(cfg.kcols);
    row_more = (ore_s + CW'(cfg.step)) <= lim_r;
    col_more = (oce_s + CW'(cfg.step)) <= lim_c;
    last_w   = !(ch_more | kr_more | kc_more | row_more | col_more);
  end

  // Odometer advance, output column fastest.
  always_comb begin
    chan_next = ce;
    krow_next = kre;
    kcol_next = kce;
    orow_next = ore;
    ocol_next = oce;
    if (bad) begin
      chan_next = '0;
      krow_next = '0;
      kcol_next = '0;
      orow_next = '0;
      ocol_next = '0;
    end else if (col_more) begin
      ocol_next = oce + OIDX_W'(1);
    end else begin
      ocol_next = '0;
      if (row_more) begin
        orow_next = ore + OIDX_W'(1);
      end else begin
        orow_next = '0;
        if (kc_more) begin
          kcol_next = kce + 4'd1;
        end else begin
          kcol_next = '0;
          if (kr_more) begin
            krow_next = kre + 4'd1;
          end else begin
            krow_next = '0;
            chan_next = ch_more ? ce + IDX_W'(1) : '0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      chan_idx <= '0;
      krow_idx <= '0;
      kcol_idx <= '0;
      orow_idx <= '0;
      ocol_idx <= '0;
      s1_valid <= 1'b0;
    end else begin
      if (accept) begin
        chan_idx <= chan_next;
        krow_idx <= krow_next;
        kcol_idx <= kcol_next;
        orow_idx <= orow_next;
        ocol_idx <= ocol_next;
      end
      if (advance) begin
        s1_valid <= accept;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_flags.bad  <= bad;
      s1_flags.last <= last_w;
      s1_chan       <= ce;
      s1_krow       <= kre;
      s1_kcol       <= kce;
      s1_row_base   <= ore_s[RB_W-1:0];
      s1_col_base   <= oce_s[RB_W-1:0];
      s1_base       <= image_base;
    end
  end

`ifndef SYNTH
  a_wrap_to_start: assert property (@(posedge clk) disable iff (rst)
    accept && (bad || last_w) |=>
      chan_idx == '0 && krow_idx == '0 && kcol_idx == '0 &&
      orow_idx == '0 && ocol_idx == '0)
    else $error("walk did not return to the first element");

  a_walk_progress: assert property (@(posedge clk) disable iff (rst)
    accept && !bad && !last_w |=>
      !(chan_idx == '0 && krow_idx == '0 && kcol_idx == '0 &&
        orow_idx == '0 && ocol_idx == '0))
    else $error("walk fell back to the start before the last element");
`endif

endmodule

`default_nettype wire

/* rtl/iag_addr_pipe.sv */
// iag_addr_pipe: source position, padding test and address sum, three stages.
// Ends in the result register. Depends on iag_pkg.
`default_nettype none

module iag_addr_pipe #(
  parameter int MAX_DIM   = 1024,
  parameter int ADDR_BITS = 32,
  localparam int DIM_MAX = (MAX_DIM > 2047) ? 2047 : MAX_DIM,
  localparam int DIM_W   = $clog2(DIM_MAX + 1),
  localparam int IDX_W   = $clog2(DIM_MAX),
  localparam int NW      = DIM_W + 5,
  localparam int RB_W    = NW - 1,
  localparam int PW      = NW + 1,
  localparam int HW_W    = 2 * DIM_W,
  localparam int PL_W    = IDX_W + HW_W
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           advance,
  input  wire iag_pkg::iag_cfg_t              cfg,
  input  wire logic                           s1_valid,
  input  wire iag_pkg::iag_flags_t            s1_flags,
  input  wire logic [IDX_W-1:0]               s1_chan,
  input  wire logic [3:0]                     s1_krow,
  input  wire logic [3:0]                     s1_kcol,
  input  wire logic [RB_W-1:0]                s1_row_base,
  input  wire logic [RB_W-1:0]                s1_col_base,
  input  wire logic [iag_pkg::IMG_ADDR_W-1:0] s1_base,
  output logic                                out_valid,
  output iag_pkg::iag_result_t                out_payload
);
  import iag_pkg::*;

  logic [DIM_W-1:0]      h, w;
  logic [HW_W-1:0]       hw;
  logic [7:0]            tap_r, tap_c;
  logic [PW-1:0]         row_sum, col_sum;
  logic [PL_W-1:0]       plane_w;

  logic                  s2_valid;
  iag_flags_t            s2_flags;
  logic [PW-1:0]         s2_row, s2_col;
  logic [PL_W-1:0]       s2_plane;
  logic [IMG_ADDR_W-1:0] s2_base;

  logic                  row_in, col_in;
  logic [HW_W-1:0]       rw_w;
  logic [ADDR_BITS-1:0]  basepc_w;

  logic                  s3_valid;
  iag_flags_t            s3_flags;
  logic                  s3_pad;
  logic [HW_W-1:0]       s3_rw;
  logic [ADDR_BITS-1:0]  s3_basepc;

  logic [ADDR_BITS-1:0]  addr_w;
  logic                  zero_w;

  assign h = cfg.height[DIM_W-1:0];
  assign w = cfg.width[DIM_W-1:0];

  // Plane size, a register; settles after a config write, before any use.
  always_ff @(posedge clk) begin
    hw <= h * w;
  end

  // Stage 2: signed source row/column, channel plane offset.
  always_comb begin
    tap_r   = s1_krow * cfg.spacing;
    tap_c   = s1_kcol * cfg.spacing;
    row_sum = PW'(s1_row_base) + PW'(tap_r) - PW'(cfg.pad);
    col_sum = PW'(s1_col_base) + PW'(tap_c) - PW'(cfg.pad);
    plane_w = s1_chan * hw;
  end

  // Stage 3: bounds test, row times width, base plus plane plus column.
  always_comb begin
    row_in   = !s2_row[PW-1] && (s2_row[PW-2:0] < (PW-1)'(h));
    col_in   = !s2_col[PW-1] && (s2_col[PW-2:0] < (PW-1)'(w));
    rw_w     = s2_row[DIM_W-1:0] * w;
    basepc_w = ADDR_BITS'(s2_base) + ADDR_BITS'(s2_plane) + ADDR_BITS'(s2_col[DIM_W-1:0]);
  end

  assign addr_w = s3_basepc + ADDR_BITS'(s3_rw);
  assign zero_w = s3_flags.bad | s3_pad;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (advance) begin
      s2_valid  <= s1_valid;
      s3_valid  <= s2_valid;
      out_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s2_flags  <= s1_flags;
      s2_row    <= row_sum;
      s2_col    <= col_sum;
      s2_plane  <= plane_w;
      s2_base   <= s1_base;

      s3_flags  <= s2_flags;
      s3_pad    <= !(row_in && col_in);
      s3_rw     <= rw_w;
      s3_basepc <= basepc_w;

      out_payload.src_address <= zero_w ? '0 : IMG_ADDR_W'(addr_w);
      out_payload.is_pad      <= zero_w;
      out_payload.last        <= s3_flags.bad | s3_flags.last;
      out_payload.bad_config  <= s3_flags.bad;
    end
  end

`ifndef SYNTH
  a_stage_hold: assert property (@(posedge clk) disable iff (rst)
    s3_valid && !advance |=> s3_valid && $stable(s3_basepc) && $stable(s3_rw))
    else $error("stage 3 item changed while the result was stalled");

  a_stage_forward: assert property (@(posedge clk) disable iff (rst)
    s3_valid && advance |=> out_valid)
    else $error("stage 3 item did not reach the result register");

  a_pad_zero_addr: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_payload.is_pad |-> out_payload.src_address == '0)
    else $error("padding element carries a nonzero address");
`endif

endmodule

`default_nettype wire

/* rtl/im2col_address_generator.sv */
// im2col_address_generator: top level of the im2col read-address generator.
// Depends on iag_pkg, iag_item_if/iag_result_if, iag_cfg_regs, iag_walker,
// iag_addr_pipe.
//
// Usage:
//   cfg_write/cfg_index/cfg_data load the eight shape registers (channels,
//   height, width, kernel rows/cols, stride, padding, dilation). Write them
//   only while no transfer is in flight.
//   Each transfer on `item` (restart flag, image base) yields exactly one
//   transfer on `result`: the source address of the next im2col element, or
//   a padding mark, plus the end-of-image mark and the bad-window flag.
//   Walk order is channel, kernel row, kernel column, output row, output col.
//   Pipeline: the item transfer edge loads the walker register; the position
//   stage, address stage and result register follow in that order, and
//   result.valid rises once the item has reached the result register.
//   Throughput: one item per cycle, back to back, while no result is held;
//   each stage is a short step of small multiplies, adds and compares.
//   Stalls: when the result is held (valid without ready) the whole pipe
//   freezes and item.ready drops in that cycle; item.ready otherwise stays
//   high, so new items enter while results are still draining.
//   Reset (rst, synchronous): registers back to 1 (padding 0), walk
//   position to the first element, pipeline emptied.
`default_nettype none

module im2col_address_generator #(
  parameter int ADDR_BITS = 32,
  parameter int MAX_DIM   = 1024,
  localparam int DIM_MAX = (MAX_DIM > 2047) ? 2047 : MAX_DIM,
  localparam int DIM_W   = $clog2(DIM_MAX + 1),
  localparam int IDX_W   = $clog2(DIM_MAX),
  localparam int RB_W    = DIM_W + 4
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_write,
  input  wire logic [iag_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [iag_pkg::CFG_DATA_W-1:0]  cfg_data,
  iag_item_if.sink                             item,
  iag_result_if.source                         result
);
  import iag_pkg::*;

  iag_cfg_t              cfg;
  logic                  advance, accept;
  logic                  out_valid;
  iag_result_t           out_payload;

  logic                  s1_valid;
  iag_flags_t            s1_flags;
  logic [IDX_W-1:0]      s1_chan;
  logic [3:0]            s1_krow, s1_kcol;
  logic [RB_W-1:0]       s1_row_base, s1_col_base;
  logic [IMG_ADDR_W-1:0] s1_base;

  // Whole pipe moves together: it advances unless a result is being held.
  assign advance = !out_valid || result.ready;
  assign accept  = item.valid && advance;

  assign item.ready     = advance;
  assign result.valid   = out_valid;
  assign result.payload = out_payload;

  iag_cfg_regs #(.MAX_DIM(MAX_DIM)) u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Walk counters; bounds are derived live from the registers every cycle.
  iag_walker #(.MAX_DIM(MAX_DIM)) u_walker (
    .clk         (clk),
    .rst         (rst),
    .advance     (advance),
    .accept      (accept),
    .restart     (item.payload.restart),
    .image_base  (item.payload.image_base),
    .cfg         (cfg),
    .s1_valid    (s1_valid),
    .s1_flags    (s1_flags),
    .s1_chan     (s1_chan),
    .s1_krow     (s1_krow),
    .s1_kcol     (s1_kcol),
    .s1_row_base (s1_row_base),
    .s1_col_base (s1_col_base),
    .s1_base     (s1_base)
  );

  // Position, padding test and address sum, then the result register.
  iag_addr_pipe #(.MAX_DIM(MAX_DIM), .ADDR_BITS(ADDR_BITS)) u_pipe (
    .clk         (clk),
    .rst         (rst),
    .advance     (advance),
    .cfg         (cfg),
    .s1_valid    (s1_valid),
    .s1_flags    (s1_flags),
    .s1_chan     (s1_chan),
    .s1_krow     (s1_krow),
    .s1_kcol     (s1_kcol),
    .s1_row_base (s1_row_base),
    .s1_col_base (s1_col_base),
    .s1_base     (s1_base),
    .out_valid   (out_valid),
    .out_payload (out_payload)
  );

endmodule

`default_nettype wire

/* tb/sv/testbench.sv */
// testbench: self-checking bench for im2col_address_generator.
// Directed stimulus table, then random shape phases, scoreboarded against
// an in-bench model of the im2col walk. Depends on iag_pkg and iag_stream_if.

module testbench;
  import iag_pkg::*;

  localparam int PIPE_LATENCY = 4;                   // item transfer to earliest result transfer
  localparam int DRAIN_CYCLES = 2 * PIPE_LATENCY + 2;
  localparam int DIM_LIMIT    = 1024;                // block's MAX_DIM
  localparam int RANDOM_ITEMS = 1900;
  localparam int HOLD_AT      = 700;                 // accepted items before the long hold-off
  localparam int HOLD_CYCLES  = 120;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int PRINT_LIMIT  = 40;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;
  typedef enum {SINK_OPEN, SINK_RANDOM, SINK_PERIODIC, SINK_SPARSE} sink_mode_t;

  // One line of the directed table: either a full shape write or one item.
  // An item row may carry a hand-written expectation.
  typedef struct packed {
    row_kind_t                   kind;
    logic [7:0][CFG_DATA_W-1:0]  regs;
    logic                        restart;
    logic [IMG_ADDR_W-1:0]       base;
    logic                        fixed;
    iag_result_t                 want;
  } stim_row_t;

  logic                   clk;
  logic                   rst;
  logic                   cfg_write;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  iag_item_if   item_ch ();
  iag_result_if result_ch ();

  im2col_address_generator dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .item      (item_ch),
    .result    (result_ch)
  );

  // 2-unit clock
  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  int cycle_count = 0;
  always @(posedge clk) cycle_count <= cycle_count + 1;

  // Watchdog: a hung handshake ends the run here.
  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("status: fail");
    $finish;
  end

  // ---------------------------------------------------------------------
  // Shape registers as the block sees them, plus the walk position.
  // Updated at the same edges where the block takes writes and items.
  // ---------------------------------------------------------------------
  logic [CFG_DATA_W-1:0] shape_reg [0:7];
  longint chan_pos, krow_pos, kcol_pos, orow_pos, ocol_pos;

  iag_result_t pending_elements [$];   // expected results, oldest first
  int          accepted_items = 0;
  int          mismatches     = 0;

  // Side info that travels with the item being offered.
  logic        item_fixed;
  iag_result_t item_want;

  function automatic void rewind_walk();
    chan_pos = 0; krow_pos = 0; kcol_pos = 0; orow_pos = 0; ocol_pos = 0;
  endfunction

  function automatic longint clip_dim(logic [CFG_DATA_W-1:0] v);
    return (v > DIM_LIMIT) ? longint'(DIM_LIMIT) : longint'(v);
  endfunction

  // Output extent by the floor formula; 0 when the window does not fit.
  function automatic longint out_extent(longint n, longint k, longint s, longint p, longint d);
    longint num;
    num = n + 2 * p - d * (k - 1) - 1;
    if (num < 0) return 0;
    return num / s + 1;
  endfunction

  // Element the block must produce for this item; advances the walk.
  function automatic iag_result_t next_element(iag_item_t it);
    longint      ch, h, w, kr, kc, s, p, d, oh, ow;
    longint      src_row, src_col, plane;
    logic [63:0] addr;
    iag_result_t r;
    ch = clip_dim(shape_reg[REG_NUM_CHANNELS]);
    if (ch == 0) ch = 1;
    h  = clip_dim(shape_reg[REG_IN_HEIGHT]);
    w  = clip_dim(shape_reg[REG_IN_WIDTH]);
    kr = longint'(shape_reg[REG_KERNEL_ROWS][CFG_TAP_W-1:0]);
    kc = longint'(shape_reg[REG_KERNEL_COLS][CFG_TAP_W-1:0]);
    s  = longint'(shape_reg[REG_STEP_SIZE][CFG_TAP_W-1:0]);
    p  = longint'(shape_reg[REG_PAD_SIZE][CFG_TAP_W-1:0]);
    d  = longint'(shape_reg[REG_TAP_SPACING][CFG_TAP_W-1:0]);
    if (kr == 0) kr = 1;
    if (kc == 0) kc = 1;
    if (s == 0) s = 1;
    oh = out_extent(h, kr, s, p, d);
    ow = out_extent(w, kc, s, p, d);
    r = '0;
    if (it.restart) rewind_walk();
    if (oh <= 0 || ow <= 0) begin
      rewind_walk();
      r.is_pad     = 1'b1;
      r.last       = 1'b1;
      r.bad_config = 1'b1;
      return r;
    end
    // shape may have shrunk under a walk in progress
    if (chan_pos >= ch) chan_pos = 0;
    if (krow_pos >= kr) krow_pos = 0;
    if (kcol_pos >= kc) kcol_pos = 0;
    if (orow_pos >= oh) orow_pos = 0;
    if (ocol_pos >= ow) ocol_pos = 0;
    src_row = orow_pos * s - p + krow_pos * d;
    src_col = ocol_pos * s - p + kcol_pos * d;
    plane   = chan_pos * h * w;
    r.is_pad = !(src_row >= 0 && src_row < h && src_col >= 0 && src_col < w);
    if (!r.is_pad) begin
      addr = longint'(it.image_base) + plane + src_row * w + src_col;
      r.src_address = addr[IMG_ADDR_W-1:0];
    end
    r.last = (chan_pos == ch - 1) && (krow_pos == kr - 1) && (kcol_pos == kc - 1) &&
             (orow_pos == oh - 1) && (ocol_pos == ow - 1);
    // output column fastest, channel slowest
    if (ocol_pos + 1 < ow) ocol_pos++;
    else begin
      ocol_pos = 0;
      if (orow_pos + 1 < oh) orow_pos++;
      else begin
        orow_pos = 0;
        if (kcol_pos + 1 < kc) kcol_pos++;
        else begin
          kcol_pos = 0;
          if (krow_pos + 1 < kr) krow_pos++;
          else begin
            krow_pos = 0;
            if (chan_pos + 1 < ch) chan_pos++;
            else chan_pos = 0;
          end
        end
      end
    end
    return r;
  endfunction

  task automatic flag_mismatch(string msg);
    if (mismatches < PRINT_LIMIT) $display("mismatch @%0d: %s", cycle_count, msg);
    mismatches++;
  endtask

  task automatic check_field(string name, int idx, logic [IMG_ADDR_W-1:0] got,
                             logic [IMG_ADDR_W-1:0] want);
    if (got !== want)
      flag_mismatch($sformatf("result %0d %s got %h want %h", idx, name, got, want));
  endtask

  // ---------------------------------------------------------------------
  // Monitor: everything sampled at the rising edge, pre-edge values.
  // Register writes, item transfers and result transfers are taken here.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin : monitor
    iag_result_t predicted;
    iag_result_t want;
    int          result_idx;
    if (rst) begin
      shape_reg[REG_NUM_CHANNELS] = CFG_DATA_W'(1);
      shape_reg[REG_IN_HEIGHT]    = CFG_DATA_W'(1);
      shape_reg[REG_IN_WIDTH]     = CFG_DATA_W'(1);
      shape_reg[REG_KERNEL_ROWS]  = CFG_DATA_W'(1);
      shape_reg[REG_KERNEL_COLS]  = CFG_DATA_W'(1);
      shape_reg[REG_STEP_SIZE]    = CFG_DATA_W'(1);
      shape_reg[REG_PAD_SIZE]     = '0;
      shape_reg[REG_TAP_SPACING]  = CFG_DATA_W'(1);
      rewind_walk();
      result_idx = 0;
    end else begin
      if (cfg_write) shape_reg[cfg_index] = cfg_data;
      if (item_ch.valid && item_ch.ready) begin
        predicted = next_element(item_ch.payload);
        // hand-written rows override the model's answer
        pending_elements = {pending_elements, (item_fixed ? item_want : predicted)};
        accepted_items++;
      end
      if (result_ch.valid && result_ch.ready) begin
        if (pending_elements.size() == 0) begin
          flag_mismatch($sformatf("result %0d with nothing pending", result_idx));
        end else begin
          want = pending_elements.pop_front();
          check_field("src_address", result_idx, result_ch.payload.src_address,
                      want.src_address);
          check_field("is_pad", result_idx, IMG_ADDR_W'(result_ch.payload.is_pad),
                      IMG_ADDR_W'(want.is_pad));
          check_field("last", result_idx, IMG_ADDR_W'(result_ch.payload.last),
                      IMG_ADDR_W'(want.last));
          check_field("bad_config", result_idx, IMG_ADDR_W'(result_ch.payload.bad_config),
                      IMG_ADDR_W'(want.bad_config));
        end
        result_idx++;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Receiver: ready follows a pattern that is drawn anew at random intervals.
  // Once, after HOLD_AT items, ready stays low for HOLD_CYCLES so the pipe
  // fills and item.ready has to drop.
  // ---------------------------------------------------------------------
  logic long_hold_done = 1'b0;

  initial begin : receiver
    sink_mode_t mode;
    int         span;
    int         tick;
    mode = SINK_OPEN;
    span = 0;
    tick = 0;
    result_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!long_hold_done && accepted_items >= HOLD_AT) begin
        result_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        long_hold_done = 1'b1;
      end else begin
        if (span == 0) begin
          mode = sink_mode_t'($urandom_range(0, mode.num() - 1));
          span = $urandom_range(10, 200);
        end
        span--;
        tick++;
        case (mode)
          SINK_OPEN:     result_ch.ready <= 1'b1;
          SINK_RANDOM:   result_ch.ready <= ($urandom_range(0, 3) != 0);
          SINK_PERIODIC: result_ch.ready <= ((tick % 5) < 3);
          SINK_SPARSE:   result_ch.ready <= ((tick % 4) == 0);
          default:       result_ch.ready <= 1'b1;
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------
  // Sender: bursts of random length, random gaps in between. gaps_on off
  // gives back-to-back stretches.
  // ---------------------------------------------------------------------
  int burst_left = 0;
  bit gaps_on    = 1'b1;

  task automatic offer_item(logic restart, logic [IMG_ADDR_W-1:0] base, logic fixed,
                            iag_result_t want);
    int gap;
    if (burst_left == 0) begin
      gap = gaps_on ? $urandom_range(0, 6) : 0;
      if (gap > 0) begin
        item_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    item_ch.valid              <= 1'b1;
    item_ch.payload.restart    <= restart;
    item_ch.payload.image_base <= base;
    item_fixed                 <= fixed;
    item_want                  <= want;
    do @(posedge clk); while (!item_ch.ready);
    burst_left--;
  endtask

  // Stop offering and wait until every pending result is out, then let
  // the pipe run empty before touching registers.
  task automatic settle();
    item_ch.valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending_elements.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_shape(logic [7:0][CFG_DATA_W-1:0] regs);
    cfg_reg_t r;
    r = r.first();
    repeat (r.num()) begin
      cfg_write <= 1'b1;
      cfg_index <= r;
      cfg_data  <= regs[r];
      @(posedge clk);
      r = r.next();
    end
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  function automatic stim_row_t shape_row(int ch, int h, int w, int kr, int kc,
                                          int st, int pd, int sp);
    stim_row_t row;
    row = '0;
    row.kind = ROW_CFG;
    row.regs[REG_NUM_CHANNELS] = CFG_DATA_W'(ch);
    row.regs[REG_IN_HEIGHT]    = CFG_DATA_W'(h);
    row.regs[REG_IN_WIDTH]     = CFG_DATA_W'(w);
    row.regs[REG_KERNEL_ROWS]  = CFG_DATA_W'(kr);
    row.regs[REG_KERNEL_COLS]  = CFG_DATA_W'(kc);
    row.regs[REG_STEP_SIZE]    = CFG_DATA_W'(st);
    row.regs[REG_PAD_SIZE]     = CFG_DATA_W'(pd);
    row.regs[REG_TAP_SPACING]  = CFG_DATA_W'(sp);
    return row;
  endfunction

  function automatic stim_row_t elem_row(logic restart, logic [IMG_ADDR_W-1:0] base);
    stim_row_t row;
    row = '0;
    row.kind    = ROW_ITEM;
    row.restart = restart;
    row.base    = base;
    return row;
  endfunction

  function automatic stim_row_t known_row(logic restart, logic [IMG_ADDR_W-1:0] base,
                                          logic [IMG_ADDR_W-1:0] addr, logic pad,
                                          logic last, logic bad);
    stim_row_t row;
    row = elem_row(restart, base);
    row.fixed            = 1'b1;
    row.want.src_address = addr;
    row.want.is_pad      = pad;
    row.want.last        = last;
    row.want.bad_config  = bad;
    return row;
  endfunction

  // ---------------------------------------------------------------------
  // Main sequence: reset, directed table, random phases, drain, verdict.
  // ---------------------------------------------------------------------
  initial begin : stimulus
    stim_row_t                  directed [$];
    stim_row_t                  row;
    logic [7:0][CFG_DATA_W-1:0] regs;
    cfg_reg_t                   r;
    logic [IMG_ADDR_W-1:0]      base;
    logic                       restart;
    int                         flavor;
    int                         phase_items;
    int                         random_items;

    item_ch.valid   <= 1'b0;
    item_ch.payload <= '0;
    item_fixed      <= 1'b0;
    item_want       <= '0;
    cfg_write       <= 1'b0;
    cfg_index       <= REG_NUM_CHANNELS;
    cfg_data        <= '0;
    rst             <= 1'b1;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Reset shape is a 1x1 image with a 1x1 kernel: every element is the
    // base itself and closes the image.
    directed = {directed, known_row(1'b0, 32'h0000_0000, 32'h0000_0000, 1'b0, 1'b1, 1'b0)};
    directed = {directed, known_row(1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 1'b1, 1'b0)};
    directed = {directed, known_row(1'b0, 32'h8000_0000, 32'h8000_0000, 1'b0, 1'b1, 1'b0)};
    directed = {directed, known_row(1'b0, 32'h5555_AAAA, 32'h5555_AAAA, 1'b0, 1'b1, 1'b0)};
    // 3x3 kernel with padding 1: the first tap sits on the top border.
    directed = {directed, shape_row(2, 3, 3, 3, 3, 1, 1, 1)};
    directed = {directed, known_row(1'b1, 32'h0000_1000, 32'h0000_0000, 1'b1, 1'b0, 1'b0)};
    directed = {directed, elem_row(1'b0, 32'h0000_1000)};
    directed = {directed, elem_row(1'b0, 32'h0000_1000)};
    directed = {directed, elem_row(1'b0, 32'h0000_1000)};
    // No padding: first element reads the base; walk left mid-image on purpose.
    directed = {directed, shape_row(3, 4, 5, 2, 2, 1, 0, 1)};
    directed = {directed, known_row(1'b1, 32'h0000_0100, 32'h0000_0100, 1'b0, 1'b0, 1'b0)};
    directed = {directed, elem_row(1'b0, 32'h0000_0100)};
    // Kernel taller than the image: window does not fit.
    directed = {directed, shape_row(1, 2, 2, 5, 1, 1, 0, 1)};
    directed = {directed, known_row(1'b0, 32'h1234_5678, 32'h0000_0000, 1'b1, 1'b1, 1'b1)};
    directed = {directed, known_row(1'b1, 32'h1234_5678, 32'h0000_0000, 1'b1, 1'b1, 1'b1)};
    // Zero width without padding is also a misfit.
    directed = {directed, shape_row(1, 4, 0, 1, 1, 1, 0, 1)};
    directed = {directed, known_row(1'b0, 32'h0000_0040, 32'h0000_0000, 1'b1, 1'b1, 1'b1)};
    // Zero height with padding: a walk of nothing but padding marks.
    directed = {directed, shape_row(1, 0, 3, 1, 1, 1, 1, 1)};
    directed = {directed, elem_row(1'b1, 32'h0000_0200)};
    directed = {directed, elem_row(1'b0, 32'h0000_0200)};
    directed = {directed, elem_row(1'b0, 32'h0000_0200)};
    // Zero channels, kernel rows, step and spacing; all taps coincide.
    directed = {directed, shape_row(0, 3, 3, 0, 3, 0, 0, 0)};
    directed = {directed, elem_row(1'b1, 32'h0000_0300)};
    directed = {directed, elem_row(1'b0, 32'h0000_0300)};
    directed = {directed, elem_row(1'b0, 32'h0000_0300)};
    // All registers at their top codes; dimensions saturate.
    directed = {directed, shape_row(2047, 2047, 2047, 15, 15, 15, 15, 15)};
    directed = {directed, elem_row(1'b1, 32'hFFFF_FFF0)};
    directed = {directed, elem_row(1'b0, 32'hFFFF_FFF0)};
    directed = {directed, elem_row(1'b0, 32'hFFFF_FFF0)};
    // Top of the address space: the second element wraps to zero.
    directed = {directed, shape_row(2047, 1024, 1024, 1, 1, 1, 0, 1)};
    directed = {directed, known_row(1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0)};
    directed = {directed, elem_row(1'b0, 32'hFFFF_FFFF)};

    while (directed.size() != 0) begin
      row = directed.pop_front();
      if (row.kind == ROW_CFG) begin
        settle();
        write_shape(row.regs);
      end else begin
        offer_item(row.restart, row.base, row.fixed, row.want);
      end
    end

    // Random phases. Most are small shapes whose walks complete many times
    // over; the rest are full-range codes and corner codes.
    random_items = 0;
    base = $urandom;
    while (random_items < RANDOM_ITEMS) begin
      settle();
      flavor = $urandom_range(0, 9);
      r = r.first();
      repeat (r.num()) begin
        if (flavor == 0) regs[r] = CFG_DATA_W'($urandom);
        else if (flavor == 1) begin
          case ($urandom_range(0, 2))
            0:       regs[r] = '0;
            1:       regs[r] = CFG_DATA_W'(1);
            default: regs[r] = '1;
          endcase
        end
        r = r.next();
      end
      if (flavor >= 2) begin
        regs[REG_NUM_CHANNELS] = CFG_DATA_W'($urandom_range(1, 3));
        regs[REG_IN_HEIGHT]    = CFG_DATA_W'($urandom_range(1, 7));
        regs[REG_IN_WIDTH]     = CFG_DATA_W'($urandom_range(1, 7));
        regs[REG_KERNEL_ROWS]  = CFG_DATA_W'($urandom_range(1, 3));
        regs[REG_KERNEL_COLS]  = CFG_DATA_W'($urandom_range(1, 3));
        regs[REG_STEP_SIZE]    = CFG_DATA_W'($urandom_range(1, 3));
        regs[REG_PAD_SIZE]     = CFG_DATA_W'($urandom_range(0, 2));
        regs[REG_TAP_SPACING]  = CFG_DATA_W'($urandom_range(1, 2));
        phase_items = $urandom_range(30, 160);
      end else begin
        phase_items = $urandom_range(10, 40);
      end
      write_shape(regs);
      gaps_on = ($urandom_range(0, 3) != 0);

      repeat (phase_items) begin
        // restarts are rare, at the start of a phase and mid-walk alike
        if (phase_items != 0 && random_items >= 0 && burst_left >= 0)
          restart = ($urandom_range(0, 39) == 0);
        if (restart) begin
          base = ($urandom_range(0, 7) == 0) ? {24'hFFFFFF, 8'($urandom)} : $urandom;
        end else if ($urandom_range(0, 29) == 0) begin
          base = $urandom;   // base moved under a running image
        end
        offer_item(restart, base, 1'b0, '0);
        random_items++;
      end
      if ($urandom_range(0, 3) != 0) begin
        // a restart with a random base rewinds the walk before the next phase
        settle();
        offer_item(1'b1, $urandom, 1'b0, '0);
        random_items++;
      end
    end

    settle();
    if (pending_elements.size() != 0)
      flag_mismatch($sformatf("%0d results never arrived", pending_elements.size()));
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

/* im2col_address_generator.f */
rtl/iag_pkg.sv
rtl/iag_stream_if.sv
rtl/iag_cfg_regs.sv
rtl/iag_walker.sv
rtl/iag_addr_pipe.sv
rtl/im2col_address_generator.sv
tb/sv/testbench.sv
